@@ hdl/bpgc_pkg.sv @@
// Package for the button press gesture classifier.
// Holds the timer width, phase and gesture codes, shared types and timer helpers.
// No dependencies.
package bpgc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int DEB_W      = 8;
    localparam int LIM_W      = 16;
    localparam int CMP_W      = (TIMER_BITS > LIM_W) ? TIMER_BITS : LIM_W;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [KIND_W-1:0]     t_kind;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    localparam t_timer TIMER_MAX = '1;

    localparam t_kind KIND_SINGLE = 2'd0;
    localparam t_kind KIND_DOUBLE = 2'd1;
    localparam t_kind KIND_LONG   = 2'd2;

    localparam t_cfg_idx CFG_DEBOUNCE = 2'd0;
    localparam t_cfg_idx CFG_LONG     = 2'd1;
    localparam t_cfg_idx CFG_WINDOW   = 2'd2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd50;
    localparam logic [LIM_W-1:0] LONG_RESET     = 16'd1500;
    localparam logic [LIM_W-1:0] WINDOW_RESET   = 16'd400;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_DEBOUNCE  = 6'b000010,
        PH_HELD      = 6'b000100,
        PH_WINDOW    = 6'b001000,
        PH_DEBOUNCE2 = 6'b010000,
        PH_RELEASE   = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase phase;
        t_timer elapsed;
    } t_state;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_ticks;
        logic [LIM_W-1:0] long_press_ticks;
        logic [LIM_W-1:0] double_window_ticks;
    } t_cfg;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_result;

    function automatic t_timer timer_inc(input t_timer value);
        t_timer res;
        res = (value == TIMER_MAX) ? TIMER_MAX : value + t_timer'(1);
        return res;
    endfunction

    // The count has reached a limit once it meets the limit or the timer ceiling.
    function automatic logic timer_reached(input t_timer value,
                                           input logic [LIM_W-1:0] limit);
        logic [CMP_W-1:0] v_ext;
        logic [CMP_W-1:0] l_ext;
        v_ext = CMP_W'(value);
        l_ext = CMP_W'(limit);
        return (v_ext >= l_ext) || (value == TIMER_MAX);
    endfunction

endpackage

@@ hdl/bpgc_if.sv @@
// Channel interfaces for the button press gesture classifier.
// Depends on bpgc_pkg for the gesture code type.
interface bpgc_tick_if;
    logic valid;
    logic ready;
    logic button_level;
    logic press_edge;

    modport source (output valid, output button_level, output press_edge, input ready);
    modport sink   (input valid, input button_level, input press_edge, output ready);
endinterface

interface bpgc_gesture_if;
    logic               valid;
    logic               ready;
    bpgc_pkg::t_kind    gesture_kind;

    modport source (output valid, output gesture_kind, input ready);
    modport sink   (input valid, input gesture_kind, output ready);
endinterface

@@ hdl/bpgc_step.sv @@
// Next-state and result logic for one tick of the gesture classifier.
// Depends on bpgc_pkg for the state, configuration and result types.
module bpgc_step (
    input  bpgc_pkg::t_state  i_state,
    input  bpgc_pkg::t_cfg    i_cfg,
    input  logic              i_button_level,
    input  logic              i_press_edge,
    output bpgc_pkg::t_state  o_state,
    output bpgc_pkg::t_result o_result
);
    import bpgc_pkg::*;

    t_timer inc;
    logic   deb_done;
    logic   win_done;
    logic   long_done;

    assign inc       = timer_inc(i_state.elapsed);
    assign deb_done  = timer_reached(inc, LIM_W'(i_cfg.debounce_ticks));
    assign win_done  = timer_reached(inc, i_cfg.double_window_ticks);
    assign long_done = timer_reached(i_state.elapsed, i_cfg.long_press_ticks);

    always_comb begin
        o_state         = i_state;
        o_result.valid  = 1'b0;
        o_result.kind   = KIND_SINGLE;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_press_edge) begin
                    o_state.phase   = PH_DEBOUNCE;
                    o_state.elapsed = '0;
                end
            end
            PH_DEBOUNCE: begin
                o_state.elapsed = inc;
                if (deb_done) begin
                    o_state.phase   = i_button_level ? PH_IDLE : PH_HELD;
                    o_state.elapsed = '0;
                end
            end
            PH_HELD: begin
                if (i_button_level) begin
                    o_state.phase   = PH_WINDOW;
                    o_state.elapsed = '0;
                end else if (long_done) begin
                    o_result.valid  = 1'b1;
                    o_result.kind   = KIND_LONG;
                    o_state.phase   = PH_RELEASE;
                    o_state.elapsed = '0;
                end else begin
                    o_state.elapsed = inc;
                end
            end
            PH_WINDOW: begin
                if (i_press_edge) begin
                    o_result.valid  = 1'b1;
                    o_result.kind   = KIND_DOUBLE;
                    o_state.phase   = PH_DEBOUNCE2;
                    o_state.elapsed = '0;
                end else if (win_done) begin
                    o_result.valid  = 1'b1;
                    o_result.kind   = KIND_SINGLE;
                    o_state.phase   = PH_IDLE;
                    o_state.elapsed = '0;
                end else begin
                    o_state.elapsed = inc;
                end
            end
            PH_DEBOUNCE2: begin
                o_state.elapsed = inc;
                if (deb_done) begin
                    o_state.phase   = PH_RELEASE;
                    o_state.elapsed = '0;
                end
            end
            PH_RELEASE: begin
                if (i_button_level) begin
                    o_state.phase   = PH_IDLE;
                    o_state.elapsed = '0;
                end
            end
            default: begin
                o_state.phase   = PH_IDLE;
                o_state.elapsed = '0;
            end
        endcase
    end

endmodule

@@ hdl/button_press_gesture_classifier.sv @@
// Top level of the button press gesture classifier.
// Depends on bpgc_pkg, the channel interfaces in bpgc_if.sv and bpgc_step.
//
// Usage: each transfer on i_tick is one 1 ms tick carrying the sampled
// active-low button level and a press-edge flag. The block tracks debounce,
// hold, double-press window and release phases, and emits a gesture code on
// o_gesture: single, double or long press. Most ticks produce no transfer.
// The three timing registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. An index beyond the last register is ignored.
// A gesture is registered in the result register, or in the skid buffer
// while the receiver stalls. Throughput: one tick per cycle while the skid
// buffer is empty, set by the single state register update per tick.
// Reset: the phase returns to idle, the timer clears, the registers take their
// defaults of 50, 1500 and 400 ticks, and no gesture is pending.
// Stall: a result register and a one-entry skid buffer hold gestures while the
// receiver stalls; i_tick.ready drops only when both are full.
module button_press_gesture_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  bpgc_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [bpgc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    bpgc_tick_if.sink                           i_tick,
    bpgc_gesture_if.source                      o_gesture
);
    import bpgc_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result step_res;
    logic    r_out_valid;
    logic    n_out_valid;
    t_kind   r_out_kind;
    t_kind   n_out_kind;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_kind   r_skid_kind;
    t_kind   n_skid_kind;
    logic    accept;
    logic    res_valid;
    logic    out_take;

    bpgc_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_button_level (i_tick.button_level),
        .i_press_edge   (i_tick.press_edge),
        .o_state        (n_state),
        .o_result       (step_res)
    );

    assign i_tick.ready           = !r_skid_valid;
    assign accept                 = i_tick.valid && !r_skid_valid;
    assign res_valid              = accept && step_res.valid;
    assign out_take               = r_out_valid && o_gesture.ready;
    assign o_gesture.valid        = r_out_valid;
    assign o_gesture.gesture_kind = r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= DEBOUNCE_RESET;
            r_cfg.long_press_ticks    <= LONG_RESET;
            r_cfg.double_window_ticks <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.debounce_ticks      <= i_cfg_data[DEB_W-1:0];
                CFG_LONG:     r_cfg.long_press_ticks    <= i_cfg_data[LIM_W-1:0];
                CFG_WINDOW:   r_cfg.double_window_ticks <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= PH_IDLE;
            r_state.elapsed <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_skid_valid = r_skid_valid;
        n_skid_kind  = r_skid_kind;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_kind   = r_skid_kind;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out_kind  = step_res.kind;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_kind  = step_res.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_kind  <= n_out_kind;
        r_skid_kind <= n_skid_kind;
    end

endmodule
